FILE: hdl/match_pair_dedup_filter_top_macros.svh
// Assertion helpers for the match pair dedup filter.
`ifndef MATCH_PAIR_DEDUP_FILTER_TOP_MACROS_SVH
`define MATCH_PAIR_DEDUP_FILTER_TOP_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define MPDF_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define MPDF_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: hdl/mpdf_pkg.sv
package mpdf_pkg;

   localparam int MAX_MATCHES_DEF = 1024;
   localparam int COORD_WIDTH_DEF = 16;

   localparam int REG_WIDTH       = 34;
   localparam int SQ_IN_WIDTH     = REG_WIDTH / 2;
   localparam int COUNT_OUT_WIDTH = 11;
   localparam int CSR_IDX_WIDTH   = 1;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [REG_WIDTH-1:0] NEAR_LEFT_SQ_RST = 34'd1254400;
   localparam logic [REG_WIDTH-1:0] NEAR_DISP_SQ_RST = 34'd25600;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_NEAR_LEFT_SQ = 1'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_NEAR_DISP_SQ = 1'd1;

   localparam logic OP_OFFER = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef struct packed {
      logic busy;
      logic hit;
   } scan_status_type;

endpackage

FILE: hdl/mpdf_ram.sv
module mpdf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/mpdf_front.sv
module mpdf_front #(
   parameter int COORD_WIDTH = mpdf_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_op,
   input  logic signed [COORD_WIDTH-1:0] req_left_x,
   input  logic signed [COORD_WIDTH-1:0] req_left_y,
   input  logic signed [COORD_WIDTH-1:0] req_right_x,
   input  logic signed [COORD_WIDTH-1:0] req_right_y,
   input  logic                          q_pop,
   output logic                          q_valid,
   output logic                          q_op,
   output logic signed [COORD_WIDTH-1:0] q_lx,
   output logic signed [COORD_WIDTH-1:0] q_ly,
   output logic signed [COORD_WIDTH:0]   q_dx,
   output logic signed [COORD_WIDTH:0]   q_dy
);

   localparam int CW    = COORD_WIDTH;
   localparam int IW    = 1 + 2 * CW + 2 * (CW + 1);
   localparam int QD    = mpdf_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(QD);
   localparam int FW    = $clog2(QD + 1);

   logic [IW-1:0]          q_ff [QD];
   logic [PW-1:0]          wr_ptr_ff, rd_ptr_ff;
   logic [FW-1:0]          fill_ff, fill_in;
   logic                   push, pop;
   logic signed [CW:0]     dx, dy;
   logic [IW-1:0]          item, head;

   assign dx = (CW + 1)'(req_left_x) - (CW + 1)'(req_right_x);
   assign dy = (CW + 1)'(req_left_y) - (CW + 1)'(req_right_y);
   assign item = {req_op, req_left_x, req_left_y, dx, dy};

   assign req_stall = (fill_ff == FW'(QD));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (fill_ff != '0);
   assign pop       = q_pop && q_valid;

   always_comb begin
      fill_in = fill_ff;
      case ({push, pop})
         2'b10:   fill_in = fill_ff + FW'(1);
         2'b01:   fill_in = fill_ff - FW'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (push) begin
            q_ff[wr_ptr_ff] <= item;
            wr_ptr_ff       <= wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
      end
   end

   assign head = q_ff[rd_ptr_ff];
   assign q_op = head[IW-1];
   assign q_lx = head[IW-2 -: CW];
   assign q_ly = head[IW-2-CW -: CW];
   assign q_dx = head[2*CW+1 -: CW+1];
   assign q_dy = head[CW:0];

endmodule

FILE: hdl/mpdf_dist.sv
module mpdf_dist #(
   parameter int COORD_WIDTH = mpdf_pkg::COORD_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  flush,
   input  logic                                  in_valid,
   input  logic signed [COORD_WIDTH-1:0]         st_lx,
   input  logic signed [COORD_WIDTH-1:0]         st_ly,
   input  logic signed [COORD_WIDTH:0]           st_dx,
   input  logic signed [COORD_WIDTH:0]           st_dy,
   input  logic signed [COORD_WIDTH-1:0]         cd_lx,
   input  logic signed [COORD_WIDTH-1:0]         cd_ly,
   input  logic signed [COORD_WIDTH:0]           cd_dx,
   input  logic signed [COORD_WIDTH:0]           cd_dy,
   input  logic [mpdf_pkg::REG_WIDTH-1:0]        near_left_sq,
   input  logic [mpdf_pkg::REG_WIDTH-1:0]        near_disp_sq,
   output mpdf_pkg::scan_status_type             status
);

   localparam int CW  = COORD_WIDTH;
   localparam int SQW = mpdf_pkg::SQ_IN_WIDTH;
   localparam int RW  = mpdf_pkg::REG_WIDTH;
   localparam int MW  = (CW + 2 > SQW + 1) ? CW + 2 : SQW + 1;
   localparam int PW  = 2 * SQW;

   logic signed [MW-1:0] diff [4];
   logic [MW-1:0]        mag  [4];
   logic [SQW-1:0]       mag_ff [4];
   logic [PW-1:0]        sq_ff  [4];
   logic                 big_l_ff, big_d_ff, big_l2_ff, big_d2_ff;
   logic                 va_ff, vb_ff;
   logic [PW:0]          sum_l, sum_d;
   logic                 lt_l, lt_d;

   assign diff[0] = MW'(st_lx) - MW'(cd_lx);
   assign diff[1] = MW'(st_ly) - MW'(cd_ly);
   assign diff[2] = MW'(st_dx) - MW'(cd_dx);
   assign diff[3] = MW'(st_dy) - MW'(cd_dy);

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         mag[i] = diff[i][MW-1] ? MW'(-diff[i]) : MW'(diff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= in_valid && !flush;
         vb_ff <= va_ff && !flush;
      end
      for (int i = 0; i < 4; i++) begin
         mag_ff[i] <= mag[i][SQW-1:0];
         sq_ff[i]  <= mag_ff[i] * mag_ff[i];
      end
      big_l_ff  <= (|mag[0][MW-1:SQW]) || (|mag[1][MW-1:SQW]);
      big_d_ff  <= (|mag[2][MW-1:SQW]) || (|mag[3][MW-1:SQW]);
      big_l2_ff <= big_l_ff;
      big_d2_ff <= big_d_ff;
   end

   assign sum_l = (PW + 1)'(sq_ff[0]) + (PW + 1)'(sq_ff[1]);
   assign sum_d = (PW + 1)'(sq_ff[2]) + (PW + 1)'(sq_ff[3]);
   assign lt_l  = !big_l2_ff && (sum_l < (PW + 1)'(near_left_sq[RW-1:0]));
   assign lt_d  = !big_d2_ff && (sum_d < (PW + 1)'(near_disp_sq[RW-1:0]));

   assign status.busy = va_ff || vb_ff;
   assign status.hit  = vb_ff && lt_l && lt_d;

endmodule

FILE: hdl/mpdf_back.sv
module mpdf_back #(
   parameter int MAX_MATCHES = mpdf_pkg::MAX_MATCHES_DEF,
   parameter int COORD_WIDTH = mpdf_pkg::COORD_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   q_valid,
   input  logic                                   q_op,
   input  logic signed [COORD_WIDTH-1:0]          q_lx,
   input  logic signed [COORD_WIDTH-1:0]          q_ly,
   input  logic signed [COORD_WIDTH:0]            q_dx,
   input  logic signed [COORD_WIDTH:0]            q_dy,
   output logic                                   q_pop,
   input  logic [mpdf_pkg::REG_WIDTH-1:0]         near_left_sq,
   input  logic [mpdf_pkg::REG_WIDTH-1:0]         near_disp_sq,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_accepted,
   output logic                                   rsp_dropped_full,
   output logic [mpdf_pkg::COUNT_OUT_WIDTH-1:0]   rsp_entry_count
);

   localparam int CW   = COORD_WIDTH;
   localparam int AW   = (MAX_MATCHES > 1) ? $clog2(MAX_MATCHES) : 1;
   localparam int CNTW = $clog2(MAX_MATCHES + 1);
   localparam int W    = 2 * CW + 2 * (CW + 1);
   localparam int OW   = mpdf_pkg::COUNT_OUT_WIDTH;
   localparam logic [CNTW-1:0] MAX_CNT = CNTW'(MAX_MATCHES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIN
   } state_type;

   state_type                state_ff;
   logic [CNTW-1:0]          count_ff, count_in;
   logic [AW-1:0]            idx_ff;
   logic                     issue_done_ff, rd_vld_ff, nearby_ff, clr_ff;
   logic                     rsp_valid_ff, rsp_accepted_ff, rsp_dropped_full_ff;
   logic [OW-1:0]            rsp_entry_count_ff;
   logic signed [CW-1:0]     cand_lx_ff, cand_ly_ff;
   logic signed [CW:0]       cand_dx_ff, cand_dy_ff;
   logic                     can_out, rd_en, wr_en, room, last_issue;
   logic                     acc_in, full_in;
   logic [W-1:0]             rd_data;
   logic signed [CW-1:0]     st_lx, st_ly;
   logic signed [CW:0]       st_dx, st_dy;
   mpdf_pkg::scan_status_type scan;

   assign can_out    = !rsp_valid_ff || !rsp_stall;
   assign q_pop      = (state_ff == ST_IDLE) && q_valid;
   assign rd_en      = (state_ff == ST_SCAN) && !issue_done_ff && !scan.hit;
   assign room       = count_ff < MAX_CNT;
   assign wr_en      = (state_ff == ST_FIN) && can_out && !clr_ff && !nearby_ff && room;
   assign last_issue = (CNTW'(idx_ff) + CNTW'(1)) == count_ff;

   always_comb begin
      count_in = count_ff;
      acc_in   = 1'b0;
      full_in  = 1'b0;
      if (clr_ff) begin
         count_in = '0;
      end else if (!nearby_ff) begin
         if (room) begin
            count_in = count_ff + CNTW'(1);
            acc_in   = 1'b1;
         end else begin
            full_in  = 1'b1;
         end
      end
   end

   mpdf_ram #(
      .WIDTH (W),
      .DEPTH (MAX_MATCHES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({cand_lx_ff, cand_ly_ff, cand_dx_ff, cand_dy_ff}),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign st_lx = rd_data[W-1 -: CW];
   assign st_ly = rd_data[W-1-CW -: CW];
   assign st_dx = rd_data[2*CW+1 -: CW+1];
   assign st_dy = rd_data[CW:0];

   mpdf_dist #(
      .COORD_WIDTH (CW)
   ) u_dist (
      .clock        (clock),
      .reset        (reset),
      .flush        (state_ff != ST_SCAN),
      .in_valid     (rd_vld_ff),
      .st_lx        (st_lx),
      .st_ly        (st_ly),
      .st_dx        (st_dx),
      .st_dy        (st_dy),
      .cd_lx        (cand_lx_ff),
      .cd_ly        (cand_ly_ff),
      .cd_dx        (cand_dx_ff),
      .cd_dy        (cand_dy_ff),
      .near_left_sq (near_left_sq),
      .near_disp_sq (near_disp_sq),
      .status       (scan)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         rd_vld_ff     <= 1'b0;
         issue_done_ff <= 1'b0;
         nearby_ff     <= 1'b0;
         clr_ff        <= 1'b0;
         idx_ff        <= '0;
      end else begin
         rd_vld_ff <= rd_en;
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_FIN) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  cand_lx_ff    <= q_lx;
                  cand_ly_ff    <= q_ly;
                  cand_dx_ff    <= q_dx;
                  cand_dy_ff    <= q_dy;
                  clr_ff        <= (q_op == mpdf_pkg::OP_CLEAR);
                  nearby_ff     <= 1'b0;
                  idx_ff        <= '0;
                  issue_done_ff <= 1'b0;
                  if (q_op == mpdf_pkg::OP_CLEAR || count_ff == '0) begin
                     state_ff <= ST_FIN;
                  end else begin
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               if (rd_en) begin
                  idx_ff <= idx_ff + AW'(1);
                  if (last_issue) begin
                     issue_done_ff <= 1'b1;
                  end
               end
               if (scan.hit) begin
                  nearby_ff <= 1'b1;
                  state_ff  <= ST_FIN;
               end else if (issue_done_ff && !rd_vld_ff && !scan.busy) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (can_out) begin
                  count_ff            <= count_in;
                  rsp_valid_ff        <= 1'b1;
                  rsp_accepted_ff     <= acc_in;
                  rsp_dropped_full_ff <= full_in;
                  rsp_entry_count_ff  <= OW'(count_in);
                  state_ff            <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_accepted_ff;
   assign rsp_dropped_full = rsp_dropped_full_ff;
   assign rsp_entry_count  = rsp_entry_count_ff;

endmodule

FILE: hdl/match_pair_dedup_filter_top.sv
// Near-duplicate filter for stereo point matches.
// Request channel (req_valid/req_stall): req_op selects an offer or a table
// clear; an offer carries left and right points in signed 1/16 px units.
// Response channel (rsp_valid/rsp_stall): one response per request with
// accepted, dropped_full and the entry count held after the request.
// Config port (csr_write/csr_index/csr_wdata): squared left-point and
// disparity thresholds; write only while the block is idle.
// A clear, or an offer against an empty table, needs no scan; an offer
// against stored matches scans them until a near match is found or all
// are read. The table scan reads one stored match per cycle from the
// single read port of the match memory, and the engine finishes one
// request before it takes up the next.
// A two-entry request queue keeps taking requests while the scan runs.
// A finished response sits in the output register; while rsp_stall is
// high it holds, and the engine may scan the next request but keeps its
// result until the register frees.
// Reset empties the table and the queue and restores default thresholds;
// table memory needs no clearing pass.
`include "match_pair_dedup_filter_top_macros.svh"

module match_pair_dedup_filter_top #(
   parameter int MAX_MATCHES = mpdf_pkg::MAX_MATCHES_DEF,
   parameter int COORD_WIDTH = mpdf_pkg::COORD_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_op,
   input  logic signed [COORD_WIDTH-1:0]          req_left_x,
   input  logic signed [COORD_WIDTH-1:0]          req_left_y,
   input  logic signed [COORD_WIDTH-1:0]          req_right_x,
   input  logic signed [COORD_WIDTH-1:0]          req_right_y,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_accepted,
   output logic                                   rsp_dropped_full,
   output logic [mpdf_pkg::COUNT_OUT_WIDTH-1:0]   rsp_entry_count,
   input  logic                                   csr_write,
   input  logic [mpdf_pkg::CSR_IDX_WIDTH-1:0]     csr_index,
   input  logic [mpdf_pkg::REG_WIDTH-1:0]         csr_wdata
);

   localparam int CW = COORD_WIDTH;
   localparam int OW = mpdf_pkg::COUNT_OUT_WIDTH;

   logic [mpdf_pkg::REG_WIDTH-1:0] near_left_sq_ff, near_disp_sq_ff;
   logic                           q_valid, q_pop, q_op;
   logic signed [CW-1:0]           q_lx, q_ly;
   logic signed [CW:0]             q_dx, q_dy;

   always_ff @(posedge clock) begin
      if (reset) begin
         near_left_sq_ff <= mpdf_pkg::NEAR_LEFT_SQ_RST;
         near_disp_sq_ff <= mpdf_pkg::NEAR_DISP_SQ_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            mpdf_pkg::CSR_NEAR_LEFT_SQ: near_left_sq_ff <= csr_wdata;
            mpdf_pkg::CSR_NEAR_DISP_SQ: near_disp_sq_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   mpdf_front #(
      .COORD_WIDTH (CW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_op      (req_op),
      .req_left_x  (req_left_x),
      .req_left_y  (req_left_y),
      .req_right_x (req_right_x),
      .req_right_y (req_right_y),
      .q_pop       (q_pop),
      .q_valid     (q_valid),
      .q_op        (q_op),
      .q_lx        (q_lx),
      .q_ly        (q_ly),
      .q_dx        (q_dx),
      .q_dy        (q_dy)
   );

   mpdf_back #(
      .MAX_MATCHES (MAX_MATCHES),
      .COORD_WIDTH (CW)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_op             (q_op),
      .q_lx             (q_lx),
      .q_ly             (q_ly),
      .q_dx             (q_dx),
      .q_dy             (q_dy),
      .q_pop            (q_pop),
      .near_left_sq     (near_left_sq_ff),
      .near_disp_sq     (near_disp_sq_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_accepted     (rsp_accepted),
      .rsp_dropped_full (rsp_dropped_full),
      .rsp_entry_count  (rsp_entry_count)
   );

   `MPDF_ASSERT_ALWAYS(a_acc_full_excl, !(rsp_valid && rsp_accepted && rsp_dropped_full), "accepted and dropped_full both set")
   `MPDF_ASSERT_IMPLY(a_acc_nonempty, rsp_valid && rsp_accepted, rsp_entry_count != '0, "accepted with empty table")
   `MPDF_ASSERT_IMPLY(a_full_count, rsp_valid && rsp_dropped_full, rsp_entry_count == OW'(MAX_MATCHES), "dropped_full below capacity")

endmodule

FILE: test/mpdf_checker.sv
module mpdf_checker (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   input  logic                                      req_stall,
   input  logic                                      req_op,
   input  logic signed [mpdf_pkg::COORD_WIDTH_DEF-1:0] req_left_x,
   input  logic signed [mpdf_pkg::COORD_WIDTH_DEF-1:0] req_left_y,
   input  logic signed [mpdf_pkg::COORD_WIDTH_DEF-1:0] req_right_x,
   input  logic signed [mpdf_pkg::COORD_WIDTH_DEF-1:0] req_right_y,
   input  logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   input  logic                                      rsp_accepted,
   input  logic                                      rsp_dropped_full,
   input  logic [mpdf_pkg::COUNT_OUT_WIDTH-1:0]      rsp_entry_count,
   input  logic                                      csr_write,
   input  logic [mpdf_pkg::CSR_IDX_WIDTH-1:0]        csr_index,
   input  logic [mpdf_pkg::REG_WIDTH-1:0]            csr_wdata,
   output int                                        errors,
   output int                                        pending,
   output int                                        n_kept,
   output int                                        n_dups,
   output int                                        n_full,
   output int                                        n_clears
);
   localparam int CW    = mpdf_pkg::COORD_WIDTH_DEF;
   localparam int DEPTH = mpdf_pkg::MAX_MATCHES_DEF;
   localparam int OW    = mpdf_pkg::COUNT_OUT_WIDTH;

   typedef struct packed {
      logic          accepted;
      logic          dropped_full;
      logic [OW-1:0] count;
   } outcome_type;

   outcome_type outcome_q[$];

   logic [mpdf_pkg::REG_WIDTH-1:0] limit_left;
   logic [mpdf_pkg::REG_WIDTH-1:0] limit_disp;
   logic signed [CW-1:0]           tab_lx [DEPTH];
   logic signed [CW-1:0]           tab_ly [DEPTH];
   logic signed [CW:0]             tab_dx [DEPTH];
   logic signed [CW:0]             tab_dy [DEPTH];
   int                             held;

   function automatic longint unsigned dist2(longint ax, longint ay, longint bx, longint by);
      longint ex;
      longint ey;
      ex = ax - bx;
      ey = ay - by;
      return ex * ex + ey * ey;
   endfunction

   // Updates the table and returns what the block should answer.
   function automatic outcome_type screen_candidate(logic op, logic signed [CW-1:0] lx,
                                                    logic signed [CW-1:0] ly,
                                                    logic signed [CW-1:0] rx,
                                                    logic signed [CW-1:0] ry);
      outcome_type        r;
      logic signed [CW:0] dx;
      logic signed [CW:0] dy;
      logic               near;
      int                 k;
      r = '0;
      if (op == mpdf_pkg::OP_CLEAR) begin
         held = 0;
      end else begin
         dx = {lx[CW-1], lx} - {rx[CW-1], rx};
         dy = {ly[CW-1], ly} - {ry[CW-1], ry};
         near = 1'b0;
         for (k = 0; k < held && !near; k++) begin
            if (dist2(tab_lx[k], tab_ly[k], lx, ly) < limit_left &&
                dist2(tab_dx[k], tab_dy[k], dx, dy) < limit_disp)
               near = 1'b1;
         end
         if (!near) begin
            if (held < DEPTH) begin
               tab_lx[held] = lx;
               tab_ly[held] = ly;
               tab_dx[held] = dx;
               tab_dy[held] = dy;
               held++;
               r.accepted = 1'b1;
            end else begin
               r.dropped_full = 1'b1;
            end
         end
      end
      r.count = OW'(held);
      return r;
   endfunction

   always @(posedge clock) begin
      outcome_type fresh;
      outcome_type oldest;
      outcome_type got;
      if (reset) begin
         limit_left = mpdf_pkg::NEAR_LEFT_SQ_RST;
         limit_disp = mpdf_pkg::NEAR_DISP_SQ_RST;
         held = 0;
         outcome_q.delete();
         pending <= 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               mpdf_pkg::CSR_NEAR_LEFT_SQ: limit_left = csr_wdata;
               mpdf_pkg::CSR_NEAR_DISP_SQ: limit_disp = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            fresh = screen_candidate(req_op, req_left_x, req_left_y, req_right_x,
                                     req_right_y);
            outcome_q.insert(outcome_q.size(), fresh);
            if (req_op == mpdf_pkg::OP_CLEAR) n_clears++;
            else if (fresh.accepted) n_kept++;
            else if (fresh.dropped_full) n_full++;
            else n_dups++;
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_accepted, rsp_dropped_full, rsp_entry_count};
            if (outcome_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("check: response with no request outstanding, %s%0b %0b %0d",
                           "got acc/full/cnt ", got.accepted, got.dropped_full, got.count);
            end else begin
               oldest = outcome_q.pop_front();
               if (got.accepted != oldest.accepted || got.dropped_full != oldest.dropped_full ||
                   got.count != oldest.count) begin
                  errors++;
                  if (errors <= 10)
                     $display("check: mismatch acc exp %0b got %0b, full exp %0b got %0b, %s%0d%s%0d",
                              oldest.accepted, got.accepted, oldest.dropped_full,
                              got.dropped_full, "cnt exp ", oldest.count, " got ", got.count);
               end
            end
         end
         pending <= outcome_q.size();
      end
   end

endmodule

FILE: test/tb.sv
module tb;

   localparam int CW          = mpdf_pkg::COORD_WIDTH_DEF;
   localparam int RW          = mpdf_pkg::REG_WIDTH;
   localparam int QUIET_LIMIT = 20000;
   localparam int PHASE_ITEMS = 112;

   localparam logic [RW-1:0]        REG_MAX = '1;
   localparam logic signed [CW-1:0] CMAX    = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] CMIN    = {1'b1, {(CW-1){1'b0}}};

   typedef struct packed {
      logic signed [CW-1:0] lx;
      logic signed [CW-1:0] ly;
      logic signed [CW-1:0] rx;
      logic signed [CW-1:0] ry;
   } pair_type;

   logic                                   clock       = 1'b0;
   logic                                   reset       = 1'b1;
   logic                                   req_valid   = 1'b0;
   logic                                   req_op      = mpdf_pkg::OP_OFFER;
   logic signed [CW-1:0]                   req_left_x  = '0;
   logic signed [CW-1:0]                   req_left_y  = '0;
   logic signed [CW-1:0]                   req_right_x = '0;
   logic signed [CW-1:0]                   req_right_y = '0;
   logic                                   rsp_stall   = 1'b0;
   logic                                   csr_write   = 1'b0;
   logic [mpdf_pkg::CSR_IDX_WIDTH-1:0]     csr_index   = mpdf_pkg::CSR_NEAR_LEFT_SQ;
   logic [RW-1:0]                          csr_wdata   = '0;
   logic                                   calm        = 1'b0;

   logic                                   req_stall;
   logic                                   rsp_valid;
   logic                                   rsp_accepted;
   logic                                   rsp_dropped_full;
   logic [mpdf_pkg::COUNT_OUT_WIDTH-1:0]   rsp_entry_count;

   int       errors, pending, n_kept, n_dups, n_full, n_clears;
   int       sent     = 0;
   int       settings = 0;
   int       quiet    = 0;
   pair_type pool[$];
   pair_type anchor;

   always #1 clock = ~clock;

   match_pair_dedup_filter_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_left_x      (req_left_x),
      .req_left_y      (req_left_y),
      .req_right_x     (req_right_x),
      .req_right_y     (req_right_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_accepted    (rsp_accepted),
      .rsp_dropped_full(rsp_dropped_full),
      .rsp_entry_count (rsp_entry_count),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   mpdf_checker filter_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_left_x      (req_left_x),
      .req_left_y      (req_left_y),
      .req_right_x     (req_right_x),
      .req_right_y     (req_right_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_accepted    (rsp_accepted),
      .rsp_dropped_full(rsp_dropped_full),
      .rsp_entry_count (rsp_entry_count),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .errors          (errors),
      .pending         (pending),
      .n_kept          (n_kept),
      .n_dups          (n_dups),
      .n_full          (n_full),
      .n_clears        (n_clears)
   );

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 11);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet <= 0;
      end else if (quiet == QUIET_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   function automatic logic signed [CW-1:0] rnd_coord();
      return CW'($urandom);
   endfunction

   task automatic issue_request(input logic op, input logic signed [CW-1:0] lx,
                                input logic signed [CW-1:0] ly,
                                input logic signed [CW-1:0] rx,
                                input logic signed [CW-1:0] ry);
      pair_type entry;
      while (!calm && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_op      <= op;
      req_left_x  <= lx;
      req_left_y  <= ly;
      req_right_x <= rx;
      req_right_y <= ry;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      if (op == mpdf_pkg::OP_OFFER) begin
         entry = '{lx, ly, rx, ry};
         pool.insert(pool.size(), entry);
         if (pool.size() > 32) void'(pool.pop_front());
      end
   endtask

   // Drain every outstanding request, then give the scan engine time to go idle.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limits(input logic [RW-1:0] left, input logic [RW-1:0] disp);
      settle();
      csr_write <= 1'b1;
      csr_index <= mpdf_pkg::CSR_NEAR_LEFT_SQ;
      csr_wdata <= left;
      @(posedge clock);
      csr_index <= mpdf_pkg::CSR_NEAR_DISP_SQ;
      csr_wdata <= disp;
      @(posedge clock);
      csr_write <= 1'b0;
      settings++;
   endtask

   task automatic random_request();
      int       pick;
      int       sx, sy, wx, wy;
      pair_type base;
      pick = $urandom_range(99);
      if (pick < 6) begin
         issue_request(mpdf_pkg::OP_CLEAR, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
      end else if (pick < 55 && pool.size() != 0) begin
         base = pool[$urandom_range(pool.size() - 1)];
         if (pick < 18) begin
            issue_request(mpdf_pkg::OP_OFFER, base.lx, base.ly, base.rx, base.ry);
         end else begin
            // shift the whole match, then nudge the disparity
            sx = int'($urandom_range(2400)) - 1200;
            sy = int'($urandom_range(2400)) - 1200;
            wx = int'($urandom_range(400)) - 200;
            wy = int'($urandom_range(400)) - 200;
            issue_request(mpdf_pkg::OP_OFFER, CW'(base.lx + sx), CW'(base.ly + sy),
                          CW'(base.rx + sx + wx), CW'(base.ry + sy + wy));
         end
      end else if (pick < 75) begin
         issue_request(mpdf_pkg::OP_OFFER, CW'(int'($urandom_range(4000)) - 2000),
                       CW'(int'($urandom_range(4000)) - 2000),
                       CW'(int'($urandom_range(4000)) - 2000),
                       CW'(int'($urandom_range(4000)) - 2000));
      end else begin
         issue_request(mpdf_pkg::OP_OFFER, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // default thresholds: 1120 units left, 160 units disparity
      issue_request(mpdf_pkg::OP_OFFER, CMAX, CMIN, CMIN, CMAX);
      issue_request(mpdf_pkg::OP_OFFER, CMAX, CMIN, CMIN, CMAX);
      issue_request(mpdf_pkg::OP_OFFER, CMIN, CMAX, CMAX, CMIN);
      issue_request(mpdf_pkg::OP_OFFER, 0, 0, 0, 0);
      issue_request(mpdf_pkg::OP_OFFER, 1120, 0, 1120, 0);
      issue_request(mpdf_pkg::OP_OFFER, 1119, 0, 1119, 0);
      issue_request(mpdf_pkg::OP_OFFER, 0, 0, 160, 0);
      issue_request(mpdf_pkg::OP_OFFER, 0, 0, 159, 0);
      issue_request(mpdf_pkg::OP_OFFER, 0, 0, 0, CMIN);
      issue_request(mpdf_pkg::OP_CLEAR, CMAX, CMIN, CMAX, CMIN);
      issue_request(mpdf_pkg::OP_CLEAR, 0, 0, 0, 0);
      issue_request(mpdf_pkg::OP_OFFER, 0, 0, 0, 0);
      issue_request(mpdf_pkg::OP_OFFER, -1, -1, -1, -1);
      issue_request(mpdf_pkg::OP_CLEAR, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());

      // both limits at the top: the first offer lands, its repeat is a duplicate
      write_limits(REG_MAX, REG_MAX);
      anchor = '{rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()};
      issue_request(mpdf_pkg::OP_OFFER, anchor.lx, anchor.ly, anchor.rx, anchor.ry);
      issue_request(mpdf_pkg::OP_OFFER, anchor.lx, anchor.ly, anchor.rx, anchor.ry);
      repeat (3)
         issue_request(mpdf_pkg::OP_OFFER, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
      issue_request(mpdf_pkg::OP_OFFER, CMAX, CMAX, CMIN, CMIN);
      issue_request(mpdf_pkg::OP_CLEAR, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: write_limits(mpdf_pkg::NEAR_LEFT_SQ_RST, mpdf_pkg::NEAR_DISP_SQ_RST);
            1: write_limits(RW'({$urandom, $urandom}), RW'({$urandom, $urandom}));
            2: write_limits(RW'($urandom_range(3000000)), RW'($urandom_range(60000)));
            3: write_limits('0, '0);
            default: write_limits(RW'($urandom_range(1 << 22)), RW'($urandom_range(1 << 16)));
         endcase
         calm <= (phase == 2);
         repeat (PHASE_ITEMS) random_request();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("tb: %0d requests over %0d threshold settings, one phase without idling",
               sent, settings);
      $display("tb: kept %0d, near duplicates %0d, dropped on full table %0d, clears %0d",
               n_kept, n_dups, n_full, n_clears);
      if (errors == 0 && pending == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/mpdf_pkg.sv
hdl/mpdf_ram.sv
hdl/mpdf_front.sv
hdl/mpdf_dist.sv
hdl/mpdf_back.sv
hdl/match_pair_dedup_filter_top.sv
test/mpdf_checker.sv
test/tb.sv
